### rtl/core/ktable_pkg.sv
// Shared widths, operation and status codes for the keyed table.
`default_nettype none
package ktable_pkg;

  localparam int KEY_W          = 16;
  localparam int OP_W           = 2;
  localparam int STATUS_W       = 3;
  localparam int PAYLOAD_W      = 64;
  localparam int ENTRY_COUNT_W  = 5;
  localparam int CAPACITY_W     = 5;

  localparam int DEPTH_DEFAULT        = 16;
  localparam int PAYLOAD_BITS_DEFAULT = 64;

  localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_UPDATE = 2'd2,
    OP_GET    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_DUP     = 3'd2,
    ST_MISSING = 3'd3,
    ST_SAME    = 3'd4
  } status_t;

endpackage
`default_nettype wire

### rtl/core/keyed_table_insert_delete_lookup.sv
// Top level of the keyed table: control sequencer, entry RAM and result register.
`default_nettype none
// Keyed table of up to DEPTH (key, payload) entries kept in insertion order in one
// synchronous RAM. Each word on the input channel is one operation (add, delete,
// update, get) and gives exactly one result word: status, the payload found by a
// get, and the entry count after the operation. Operations run one at a time.
// The search walks the used entries through the RAM read port, one entry per cycle,
// and a delete then moves every later entry down one place, again one entry per
// cycle through the same read port and the write port. A rejected add on a full
// table skips the search. The input is ready again in the cycle the result is
// loaded. A finished result waits in the output register while the next operation
// is already accepted. The capacity register is written through cfg_write/cfg_data;
// the user must write it only while the table is idle, as the block does not enforce
// it. A value above DEPTH acts as DEPTH and zero makes every add report full.
// Entries past the count are never read, so the RAM needs no clearing after reset.
module keyed_table_insert_delete_lookup
  import ktable_pkg::*;
#(
  parameter int DEPTH        = DEPTH_DEFAULT,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write,
  input  wire logic [CAPACITY_W-1:0]    cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [OP_W-1:0]          operation,
  input  wire logic [KEY_W-1:0]         key,
  input  wire logic [KEY_W-1:0]         new_key,
  input  wire logic [PAYLOAD_W-1:0]     payload,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [STATUS_W-1:0]           status,
  output logic [PAYLOAD_W-1:0]          found_payload,
  output logic [ENTRY_COUNT_W-1:0]      entry_count
);

  localparam int AW     = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > CAPACITY_W) ? CNT_W : CAPACITY_W;
  localparam int WORD_W = KEY_W + PAYLOAD_BITS;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t                    state, state_next;
  op_t                       op_q;
  logic [KEY_W-1:0]          key_q;
  logic [KEY_W-1:0]          new_key_q;
  logic [PAYLOAD_BITS-1:0]   pay_q;
  logic [CAPACITY_W-1:0]     capacity;
  logic [CNT_W-1:0]          used, used_next;
  logic [CNT_W-1:0]          scan, scan_next;
  logic                      pend, pend_next;
  logic [CNT_W-1:0]          pend_idx, pend_idx_next;
  logic [CNT_W-1:0]          pend_prev;
  status_t                   res_status, res_status_next;
  logic [PAYLOAD_BITS-1:0]   res_found, res_found_next;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [WORD_W-1:0]         ram_wdata;
  logic                      ram_re;
  logic [WORD_W-1:0]         ram_rdata;
  logic [KEY_W-1:0]          rd_key;
  logic [PAYLOAD_BITS-1:0]   rd_pay;
  logic                      table_full;
  logic                      hit;
  logic                      scan_left;

  assign rd_key    = ram_rdata[WORD_W-1:PAYLOAD_BITS];
  assign rd_pay    = ram_rdata[PAYLOAD_BITS-1:0];
  assign pend_prev = pend_idx - 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign table_full = (used >= DEPTH_CNT) || (CMP_W'(used) >= CMP_W'(capacity));
  assign hit       = pend && (rd_key == key_q);
  assign scan_left = (scan < used);

  ktable_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next      = state;
    used_next       = used;
    scan_next       = scan;
    pend_next       = pend;
    pend_idx_next   = pend_idx;
    res_status_next = res_status;
    res_found_next  = res_found;
    ram_we          = 1'b0;
    ram_waddr       = used[AW-1:0];
    ram_wdata       = {key_q, pay_q};
    ram_re          = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          res_found_next = '0;
          scan_next      = '0;
          pend_next      = 1'b0;
          if ((op_t'(operation) == OP_ADD) && table_full) begin
            res_status_next = ST_FULL;
            state_next      = S_FINISH;
          end else begin
            state_next = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (hit) begin
          res_status_next = ST_OK;
          state_next      = S_FINISH;
          unique case (op_q)
            OP_ADD: begin
              res_status_next = ST_DUP;
            end
            OP_DELETE: begin
              scan_next  = pend_idx + 1'b1;
              pend_next  = 1'b0;
              state_next = S_SHIFT;
            end
            OP_UPDATE: begin
              if (new_key_q == key_q) begin
                res_status_next = ST_SAME;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = pend_idx[AW-1:0];
                ram_wdata = {new_key_q, pay_q};
              end
            end
            OP_GET: begin
              res_found_next = rd_pay;
            end
            default: begin
              res_status_next = ST_MISSING;
            end
          endcase
        end else if (!pend && !scan_left) begin
          state_next = S_FINISH;
          if (op_q == OP_ADD) begin
            res_status_next = ST_OK;
            ram_we          = 1'b1;
            ram_waddr       = used[AW-1:0];
            used_next       = used + 1'b1;
          end else begin
            res_status_next = ST_MISSING;
          end
        end else if (scan_left) begin
          ram_re        = 1'b1;
          pend_next     = 1'b1;
          pend_idx_next = scan;
          scan_next     = scan + 1'b1;
        end else begin
          pend_next = 1'b0;
        end
      end
      S_SHIFT: begin
        if (pend) begin
          ram_we    = 1'b1;
          ram_waddr = pend_prev[AW-1:0];
          ram_wdata = ram_rdata;
        end
        if (scan_left) begin
          ram_re        = 1'b1;
          pend_next     = 1'b1;
          pend_idx_next = scan;
          scan_next     = scan + 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            used_next       = used - 1'b1;
            res_status_next = ST_OK;
            state_next      = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      pend      <= 1'b0;
      capacity  <= CAPACITY_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      used  <= used_next;
      pend  <= pend_next;
      if (cfg_write) begin
        capacity <= cfg_data;
      end
      if (state == S_FINISH && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan       <= scan_next;
    pend_idx   <= pend_idx_next;
    res_status <= res_status_next;
    res_found  <= res_found_next;
    if (in_valid && in_ready) begin
      op_q      <= op_t'(operation);
      key_q     <= key;
      new_key_q <= new_key;
      pay_q     <= payload[PAYLOAD_BITS-1:0];
    end
    if (state == S_FINISH && (!out_valid || out_ready)) begin
      status        <= res_status;
      found_payload <= PAYLOAD_W'(res_found);
      entry_count   <= ENTRY_COUNT_W'(used);
    end
  end

  a_used_bounded: assert property (@(posedge clk) disable iff (rst)
    used <= DEPTH_CNT)
    else $error("entry count above table depth");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_FINISH) |-> !ram_we)
    else $error("RAM written outside an operation");

  a_shift_addr: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && pend) |-> (pend_idx != '0 && pend_idx < used))
    else $error("shift moves an entry outside the used range");

  a_count_change: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && used != $past(used)) |->
      ($past(state) == S_SEARCH || $past(state) == S_SHIFT))
    else $error("entry count changed outside search or shift");

  a_finish_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && out_valid && !out_ready) |=> state == S_FINISH)
    else $error("result dropped while output register occupied");

endmodule
`default_nettype wire

### rtl/core/ktable_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module ktable_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### tb/keyed_table_insert_delete_lookup_tb.sv
// Self-checking testbench for the keyed table: directed table, random traffic, table predictor.
`default_nettype none
module keyed_table_insert_delete_lookup_tb
  import ktable_pkg::*;
();

  localparam int DEPTH       = DEPTH_DEFAULT;
  localparam int KEY_POOL    = 20;
  localparam int PHASES      = 9;
  localparam int PHASE_WORDS = 178;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [PAYLOAD_W-1:0] ALL_ONES = '1;

  typedef struct packed {
    status_t                    status;
    logic [PAYLOAD_W-1:0]       found;
    logic [ENTRY_COUNT_W-1:0]   count;
  } table_reply_t;

  typedef enum logic {ROW_WORD, ROW_CAP} row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    op_t                        op;
    logic [KEY_W-1:0]           k;
    logic [KEY_W-1:0]           nk;
    logic [PAYLOAD_W-1:0]       pl;
    logic                       typed;
    table_reply_t               reply;
    logic [CAPACITY_W-1:0]      cap;
  } dir_row_t;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [CAPACITY_W-1:0]      cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [OP_W-1:0]            operation = '0;
  logic [KEY_W-1:0]           key = '0;
  logic [KEY_W-1:0]           new_key = '0;
  logic [PAYLOAD_W-1:0]       payload = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [STATUS_W-1:0]        status;
  logic [PAYLOAD_W-1:0]       found_payload;
  logic [ENTRY_COUNT_W-1:0]   entry_count;
  logic                       steady = 1'b0;

  logic [KEY_W-1:0]           tbl_key [DEPTH];
  logic [PAYLOAD_W-1:0]       tbl_data [DEPTH];
  int                         tbl_count;
  logic [CAPACITY_W-1:0]      tbl_cap;
  logic [KEY_W-1:0]           key_pool [KEY_POOL];

  table_reply_t               pending_replies [$];
  dir_row_t                   dir_rows [$];
  int                         mismatches;
  int                         words_sent;
  int                         replies_seen;
  int                         cap_writes;
  int                         cycle_count;
  int                         status_seen [5];

  keyed_table_insert_delete_lookup dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .key           (key),
    .new_key       (new_key),
    .payload       (payload),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .found_payload (found_payload),
    .entry_count   (entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic table_reply_t apply_word(op_t op, logic [KEY_W-1:0] k,
                                              logic [KEY_W-1:0] nk,
                                              logic [PAYLOAD_W-1:0] pl);
    table_reply_t r;
    int pos;
    int eff_cap;
    r = '{status: ST_OK, found: '0, count: '0};
    eff_cap = (tbl_cap > DEPTH) ? DEPTH : int'(tbl_cap);
    pos = -1;
    for (int i = tbl_count - 1; i >= 0; i--) begin
      if (tbl_key[i] == k) pos = i;
    end
    case (op)
      OP_ADD: begin
        if (tbl_count >= eff_cap) begin
          r.status = ST_FULL;
        end else if (pos >= 0) begin
          r.status = ST_DUP;
        end else begin
          tbl_key[tbl_count] = k;
          tbl_data[tbl_count] = pl;
          tbl_count++;
        end
      end
      OP_DELETE: begin
        if (pos < 0) begin
          r.status = ST_MISSING;
        end else begin
          for (int j = pos; j + 1 < tbl_count; j++) begin
            tbl_key[j] = tbl_key[j + 1];
            tbl_data[j] = tbl_data[j + 1];
          end
          tbl_count--;
        end
      end
      OP_UPDATE: begin
        if (pos < 0) begin
          r.status = ST_MISSING;
        end else if (nk == k) begin
          r.status = ST_SAME;
        end else begin
          tbl_key[pos] = nk;
          tbl_data[pos] = pl;
        end
      end
      default: begin
        if (pos < 0) r.status = ST_MISSING;
        else r.found = tbl_data[pos];
      end
    endcase
    r.count = tbl_count[ENTRY_COUNT_W-1:0];
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(int present_pct);
    if (tbl_count > 0 && $urandom_range(99) < present_pct)
      return tbl_key[$urandom_range(tbl_count - 1)];
    if ($urandom_range(99) < 85)
      return key_pool[$urandom_range(KEY_POOL - 1)];
    return KEY_W'($urandom);
  endfunction

  function automatic dir_row_t word_row(op_t op, logic [KEY_W-1:0] k, logic [KEY_W-1:0] nk,
                                        logic [PAYLOAD_W-1:0] pl);
    dir_row_t row;
    row = '0;
    row.kind = ROW_WORD;
    row.op = op;
    row.k = k;
    row.nk = nk;
    row.pl = pl;
    return row;
  endfunction

  function automatic dir_row_t checked_row(op_t op, logic [KEY_W-1:0] k, logic [KEY_W-1:0] nk,
                                           logic [PAYLOAD_W-1:0] pl, status_t st,
                                           logic [PAYLOAD_W-1:0] fp,
                                           logic [ENTRY_COUNT_W-1:0] cnt);
    dir_row_t row;
    row = word_row(op, k, nk, pl);
    row.typed = 1'b1;
    row.reply = '{status: st, found: fp, count: cnt};
    return row;
  endfunction

  function automatic dir_row_t cap_row(logic [CAPACITY_W-1:0] v);
    dir_row_t row;
    row = '0;
    row.kind = ROW_CAP;
    row.cap = v;
    return row;
  endfunction

  task automatic send_word(op_t op, logic [KEY_W-1:0] k, logic [KEY_W-1:0] nk,
                           logic [PAYLOAD_W-1:0] pl, logic typed, table_reply_t typed_reply);
    table_reply_t want;
    while (!steady && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    key       <= k;
    new_key   <= nk;
    payload   <= pl;
    do @(posedge clk); while (!in_ready);
    want = apply_word(op, k, nk, pl);
    pending_replies.push_back(typed ? typed_reply : want);
    words_sent++;
  endtask

  task automatic set_capacity(logic [CAPACITY_W-1:0] v);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    tbl_cap = v;
    cap_writes++;
  endtask

  always @(posedge clk) out_ready <= steady || ($urandom_range(99) >= 33);

  always @(posedge clk) begin : check_reply
    table_reply_t want;
    table_reply_t got;
    if (!rst && out_valid && out_ready) begin
      got = '{status: status_t'(status), found: found_payload, count: entry_count};
      if (status < 5) status_seen[status]++;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: status %0d payload %h count %0d",
                   status, found_payload, entry_count);
      end else begin
        want = pending_replies.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d: expected status %0d payload %h count %0d, got %0d %h %0d",
                     replies_seen, want.status, want.found, want.count,
                     status, found_payload, entry_count);
        end
      end
      replies_seen++;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("keyed_table_insert_delete_lookup regression: fail");
    $finish;
  end

  initial begin : stimulus
    op_t op;
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] nk;
    int r;
    logic [CAPACITY_W-1:0] phase_cap [PHASES];
    phase_cap = '{5'd16, 5'd3, 5'd31, 5'd0, 5'd1, 5'd16, 5'd2, 5'd9, 5'd16};
    tbl_count = 0;
    tbl_cap = CAPACITY_RESET;
    mismatches = 0;
    words_sent = 0;
    replies_seen = 0;
    cap_writes = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (tbl_key[i]) begin
      tbl_key[i] = '0;
      tbl_data[i] = '0;
    end
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = KEY_W'($urandom);

    dir_rows.push_back(checked_row(OP_GET, 16'h0000, 16'h0000, '0, ST_MISSING, '0, 5'd0));
    dir_rows.push_back(checked_row(OP_DELETE, 16'hFFFF, 16'h0000, '0, ST_MISSING, '0, 5'd0));
    dir_rows.push_back(checked_row(OP_UPDATE, 16'h0000, 16'h0001, '0, ST_MISSING, '0, 5'd0));
    dir_rows.push_back(checked_row(OP_ADD, 16'h0000, 16'h0000, '0, ST_OK, '0, 5'd1));
    dir_rows.push_back(checked_row(OP_ADD, 16'hFFFF, 16'hFFFF, ALL_ONES, ST_OK, '0, 5'd2));
    dir_rows.push_back(checked_row(OP_ADD, 16'h0000, 16'h0000, 64'h1, ST_DUP, '0, 5'd2));
    dir_rows.push_back(checked_row(OP_GET, 16'hFFFF, 16'h0000, '0, ST_OK, ALL_ONES, 5'd2));
    dir_rows.push_back(checked_row(OP_UPDATE, 16'h0000, 16'h0000, 64'h7, ST_SAME, '0, 5'd2));
    dir_rows.push_back(word_row(OP_UPDATE, 16'h0000, 16'hFFFF, 64'h5555_5555_5555_5555));
    dir_rows.push_back(word_row(OP_GET, 16'hFFFF, 16'h0000, '0));
    dir_rows.push_back(word_row(OP_ADD, 16'h1234, 16'h0000, 64'hA5A5_A5A5_A5A5_A5A5));
    dir_rows.push_back(word_row(OP_DELETE, 16'hFFFF, 16'h0000, '0));
    dir_rows.push_back(word_row(OP_GET, 16'hFFFF, 16'h0000, '0));
    dir_rows.push_back(word_row(OP_GET, 16'h1234, 16'h0000, '0));
    dir_rows.push_back(cap_row(5'd2));
    dir_rows.push_back(checked_row(OP_ADD, 16'h4321, 16'h0000, '0, ST_FULL, '0, 5'd2));
    dir_rows.push_back(cap_row(5'd1));
    dir_rows.push_back(checked_row(OP_ADD, 16'h4321, 16'h0000, '0, ST_FULL, '0, 5'd2));
    dir_rows.push_back(word_row(OP_DELETE, 16'h1234, 16'h0000, '0));
    dir_rows.push_back(checked_row(OP_ADD, 16'h4321, 16'h0000, '0, ST_FULL, '0, 5'd1));
    dir_rows.push_back(cap_row(5'd0));
    dir_rows.push_back(checked_row(OP_ADD, 16'h4321, 16'h0000, '0, ST_FULL, '0, 5'd1));
    dir_rows.push_back(cap_row(5'd31));
    dir_rows.push_back(word_row(OP_ADD, 16'h4321, 16'h0000, 64'hDEAD_BEEF_0123_4567));
    dir_rows.push_back(word_row(OP_UPDATE, 16'hFFFF, 16'h8000, 64'h8000_0000_0000_0001));
    dir_rows.push_back(word_row(OP_GET, 16'h8000, 16'h0000, '0));
    dir_rows.push_back(word_row(OP_DELETE, 16'h4321, 16'h0000, '0));
    dir_rows.push_back(word_row(OP_DELETE, 16'h8000, 16'h0000, '0));
    dir_rows.push_back(checked_row(OP_GET, 16'h8000, 16'h0000, '0, ST_MISSING, '0, 5'd0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CAP)
        set_capacity(dir_rows[i].cap);
      else
        send_word(dir_rows[i].op, dir_rows[i].k, dir_rows[i].nk, dir_rows[i].pl,
                  dir_rows[i].typed, dir_rows[i].reply);
    end

    for (int p = 0; p < PHASES; p++) begin
      set_capacity(phase_cap[p]);
      steady <= (p == 5);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        r = $urandom_range(99);
        if (r < 40) op = OP_ADD;
        else if (r < 60) op = OP_DELETE;
        else if (r < 75) op = OP_UPDATE;
        else op = OP_GET;
        k = (op == OP_ADD) ? pick_key(15) : pick_key(70);
        nk = ($urandom_range(99) < 15) ? k : pick_key(20);
        send_word(op, k, nk, {$urandom, $urandom}, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    steady <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("%0d words sent, %0d replies checked, %0d capacity writes, %0d cycles",
             words_sent, replies_seen, cap_writes, cycle_count);
    $display("statuses: ok %0d, full %0d, duplicate %0d, not found %0d, same key %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (mismatches == 0 && pending_replies.size() == 0)
      $display("keyed_table_insert_delete_lookup regression: pass");
    else
      $display("keyed_table_insert_delete_lookup regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
